### rtl/core/progressive_mesh_triangle_collapse_defines.svh
// Assertion macros for the progressive mesh triangle collapse block.
`ifndef PROGRESSIVE_MESH_TRIANGLE_COLLAPSE_DEFINES_SVH
`define PROGRESSIVE_MESH_TRIANGLE_COLLAPSE_DEFINES_SVH
`ifndef SYNTHESIS
`define PMTC_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pmtc check failed");
`define PMTC_NEXT(label, cond, nxt) `PMTC_CHECK(label, (cond) |=> (nxt))
`else
`define PMTC_CHECK(label, prop)
`define PMTC_NEXT(label, cond, nxt)
`endif
`endif

### rtl/core/pmtc_pkg.sv
// Shared constants and controller/datapath interface types.
`default_nettype none
package pmtc_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int STEP_W      = $clog2(TABLE_DEPTH + 1);
  localparam int VTX_W       = 16;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_VTX_W   = 12;
  localparam int SLOT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DETAIL_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd1;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_MID   = 2'd1;
  localparam logic [1:0] CORNER_LAST  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       start;
    logic [1:0] sel;
    logic       rd;
    logic       step;
    logic       next_corner;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic walk_go;
    logic link_stop;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/pmtc_dpath.sv
// Datapath: config registers, collapse table, corner walk registers, kept counter, result register.
`default_nettype none
module pmtc_dpath
  import pmtc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_wdata,
  input  wire logic [11:0]                 in_entry_index,
  input  wire logic signed [12:0]          in_entry_target,
  input  wire logic [VTX_W-1:0]            in_corner_a,
  input  wire logic [VTX_W-1:0]            in_corner_b,
  input  wire logic [VTX_W-1:0]            in_corner_c,
  input  wire logic                        in_final_triangle,
  input  wire cmd_t                        cmd,
  output      sts_t                        sts,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_kept,
  output      logic [OUT_VTX_W-1:0]        out_a,
  output      logic [OUT_VTX_W-1:0]        out_b,
  output      logic [OUT_VTX_W-1:0]        out_c,
  output      logic [SLOT_W-1:0]           out_slot,
  output      logic                        out_surface_end
);

  logic [CFG_W-1:0]     limit_r;
  logic [CFG_W-1:0]     vcount_r;
  logic [12:0]          mem [TABLE_DEPTH];
  logic [12:0]          rd_data_r;
  logic [VTX_W-1:0]     crn_r [3];
  logic [VTX_W-1:0]     cur_v;
  logic [STEP_W-1:0]    steps_r;
  logic                 fin_r;
  logic [SLOT_W-1:0]    cnt_r;
  logic                 out_valid_r;
  logic                 out_kept_r;
  logic [OUT_VTX_W-1:0] out_a_r;
  logic [OUT_VTX_W-1:0] out_b_r;
  logic [OUT_VTX_W-1:0] out_c_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_end_r;
  logic [VTX_W-1:0]     limit_ext;
  logic [VTX_W-1:0]     vcount_ext;
  logic                 load_ok;
  logic                 keep;

  assign limit_ext  = VTX_W'(limit_r);
  assign vcount_ext = VTX_W'(vcount_r);
  assign load_ok    = {5'd0, in_entry_index} < 17'(TABLE_DEPTH);

  always_comb begin
    unique case (cmd.sel)
      CORNER_FIRST: cur_v = crn_r[0];
      CORNER_MID:   cur_v = crn_r[1];
      default:      cur_v = crn_r[2];
    endcase
  end

  always_comb begin
    sts.bypass    = limit_r >= vcount_r;
    sts.walk_go   = (cur_v >= limit_ext) && (cur_v < vcount_ext) &&
                    (steps_r < STEP_W'(TABLE_DEPTH)) &&
                    ({1'b0, cur_v} < 17'(TABLE_DEPTH));
    sts.link_stop = rd_data_r[12] || (VTX_W'(rd_data_r) == cur_v);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    if (sts.bypass) begin
      keep = 1'b1;
    end else begin
      keep = (crn_r[0] != crn_r[1]) && (crn_r[1] != crn_r[2]) && (crn_r[0] != crn_r[2]) &&
             (crn_r[0] < limit_ext) && (crn_r[1] < limit_ext) && (crn_r[2] < limit_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= CFG_W'(4096);
      vcount_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DETAIL_LIMIT: limit_r  <= cfg_wdata;
        REG_VERTEX_COUNT: vcount_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[TBL_AW'(in_entry_index)] <= in_entry_target;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[TBL_AW'(cur_v)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      crn_r[0] <= in_corner_a;
      crn_r[1] <= in_corner_b;
      crn_r[2] <= in_corner_c;
      fin_r    <= in_final_triangle;
      steps_r  <= '0;
    end else if (cmd.step) begin
      unique case (cmd.sel)
        CORNER_FIRST: crn_r[0] <= VTX_W'(rd_data_r);
        CORNER_MID:   crn_r[1] <= VTX_W'(rd_data_r);
        default:      crn_r[2] <= VTX_W'(rd_data_r);
      endcase
      steps_r <= steps_r + STEP_W'(1);
    end else if (cmd.next_corner) begin
      steps_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (fin_r) begin
          cnt_r <= '0;
        end else if (keep && (cnt_r != '1)) begin
          cnt_r <= cnt_r + SLOT_W'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kept_r <= keep;
      out_a_r    <= keep ? OUT_VTX_W'(crn_r[0]) : '0;
      out_b_r    <= keep ? OUT_VTX_W'(crn_r[1]) : '0;
      out_c_r    <= keep ? OUT_VTX_W'(crn_r[2]) : '0;
      out_slot_r <= cnt_r;
      out_end_r  <= fin_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kept        = out_kept_r;
  assign out_a           = out_a_r;
  assign out_b           = out_b_r;
  assign out_c           = out_c_r;
  assign out_slot        = out_slot_r;
  assign out_surface_end = out_end_r;

endmodule
`default_nettype wire

### rtl/core/pmtc_ctrl.sv
// Controller: sequences table loads and the per-corner collapse walk.
`default_nettype none
`include "progressive_mesh_triangle_collapse_defines.svh"
module pmtc_ctrl
  import pmtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire logic in_op,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_LINK,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       accept;

  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    sel_nxt         = sel_r;
    cmd             = '0;
    cmd.sel         = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            sel_nxt   = CORNER_FIRST;
            state_nxt = sts.bypass ? ST_EMIT : ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (sts.walk_go) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_LINK;
        end else if (sel_r == CORNER_LAST) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.next_corner = 1'b1;
          sel_nxt         = sel_r + 2'd1;
        end
      end
      ST_LINK: begin
        state_nxt = ST_CHK;
        if (!sts.link_stop) begin
          cmd.step = 1'b1;
        end else if (sel_r == CORNER_LAST) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.next_corner = 1'b1;
          sel_nxt         = sel_r + 2'd1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= CORNER_FIRST;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  `PMTC_CHECK(a_link_follows_chk, (state_r == ST_LINK) |-> $past(state_r == ST_CHK))
  `PMTC_CHECK(a_sel_in_range, sel_r <= CORNER_LAST)
  `PMTC_NEXT(a_emit_returns_idle, (state_r == ST_EMIT) && sts.out_free, state_r == ST_IDLE)

endmodule
`default_nettype wire

### rtl/core/progressive_mesh_triangle_collapse.sv
// Top level of the progressive mesh triangle collapse block.
//
// Load items (op 0) write one collapse table entry. Triangle
// items (op 1) walk each corner down the collapse table through the single
// read port of the 4096-entry table, one table read per step. A triangle
// goes straight to its result when detail_limit >= vertex_count. Otherwise
// each corner in turn is walked while it lies in [detail_limit, vertex_count),
// until its walk ends on a root or a self-link.
// The result sits in an output register, so the next item can be accepted while
// it waits; a triangle that finishes while that result is still waiting holds
// until it is taken. No item is accepted while rst_n is low.
// The table holds no reset value; every entry a walk can reach must be loaded
// first. The kept counter returns to zero after a triangle marked final.
`default_nettype none
module progressive_mesh_triangle_collapse
  import pmtc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic                 in_op,
  input  wire logic [11:0]          in_entry_index,
  input  wire logic signed [12:0]   in_entry_target,
  input  wire logic [VTX_W-1:0]     in_corner_a,
  input  wire logic [VTX_W-1:0]     in_corner_b,
  input  wire logic [VTX_W-1:0]     in_corner_c,
  input  wire logic                 in_final_triangle,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic                 out_kept,
  output      logic [OUT_VTX_W-1:0] out_a,
  output      logic [OUT_VTX_W-1:0] out_b,
  output      logic [OUT_VTX_W-1:0] out_c,
  output      logic [SLOT_W-1:0]    out_slot,
  output      logic                 out_surface_end
);

  cmd_t cmd;
  sts_t sts;

  pmtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmtc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_entry_index    (in_entry_index),
    .in_entry_target   (in_entry_target),
    .in_corner_a       (in_corner_a),
    .in_corner_b       (in_corner_b),
    .in_corner_c       (in_corner_c),
    .in_final_triangle (in_final_triangle),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kept          (out_kept),
    .out_a             (out_a),
    .out_b             (out_b),
    .out_c             (out_c),
    .out_slot          (out_slot),
    .out_surface_end   (out_surface_end)
  );

endmodule
`default_nettype wire
